// ----- rtl/deq_pkg.sv -----
// shared types and constants for the double-ended queue block
// no dependencies; used by the top level, the checker and the testbench
`default_nettype none

package deq_pkg;

    localparam int DATA_W       = 32;
    localparam int KIND_W       = 3;
    localparam int STATUS_W     = 3;
    localparam int CAPACITY_DEF = 32;

    // command codes
    typedef enum logic [KIND_W-1:0] {
        KIND_PUSH_FRONT = 3'd0,
        KIND_PUSH_BACK  = 3'd1,
        KIND_POP_FRONT  = 3'd2,
        KIND_POP_BACK   = 3'd3,
        KIND_REVERSE    = 3'd4,
        KIND_LIST       = 3'd5
    } kind_t;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        STATUS_DONE       = 3'd0,
        STATUS_UNDERFLOW  = 3'd1,
        STATUS_FULL       = 3'd2,
        STATUS_LISTED     = 3'd3,
        STATUS_LIST_EMPTY = 3'd4
    } status_t;

endpackage

`default_nettype wire

// ----- rtl/deq_ram.sv -----
// entry store of the queue: one write port, one read port, registered read data
// depends on nothing; sized by the top level
`default_nettype none

module deq_ram #(
    parameter int DEPTH = 32,
    parameter int AW    = 5,
    parameter int DW    = 32
) (
    input  wire logic          clk,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [DW-1:0] wr_data,
    input  wire logic          rd_en,
    input  wire logic [AW-1:0] rd_addr,
    output logic      [DW-1:0] rd_data
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ----- rtl/double_ended_queue_with_reverse_top.sv -----
// top level of the bounded double-ended queue with constant-time reverse
// depends on deq_pkg and deq_ram
`default_nettype none

// usage
// - command channel: kind and value are taken at a rising edge with start high
//   and busy low; that edge is the transaction
// - result channel: valid marks one cycle of status, item and last; the
//   receiver takes every result, it cannot stall the block
// - push, reverse, failed pop (underflow), push on full, empty list: the single
//   result shows in the cycle after the transaction, busy stays low, so a new
//   command can follow in the next cycle
// - successful pop: the entry store has registered read data, so busy is
//   high for one cycle; the result goes through the store's read register, then the result register
// - list of n entries: busy is high while the entries are fetched, results
//   stream one per cycle behind the read and result registers, last marks the final one;
//   the memory read port fetches one entry per cycle
// - kinds 6 and 7 are dropped: no result, no state change
// - entries live in a ring in the store; head, count and the reversed flag
//   sit in flops; reverse just toggles the flag and every later push, pop and
//   list maps front/back through it
// - reset clears head, count, reversed and the sequencer; the store itself is
//   not cleared, only written entries are ever read
module double_ended_queue_with_reverse_top #(
    parameter int CAPACITY = deq_pkg::CAPACITY_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic [deq_pkg::KIND_W-1:0]        kind,
    input  wire logic signed [deq_pkg::DATA_W-1:0] value,
    output logic                                   valid,
    output logic [deq_pkg::STATUS_W-1:0]           status,
    output logic signed [deq_pkg::DATA_W-1:0]      item,
    output logic                                   last
);

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_POP  = 3'b010,
        ST_LIST = 3'b100
    } state_t;

    // ring index arithmetic: base plus offset, wrapped once
    function automatic logic [IW-1:0] ring_add(input logic [IW-1:0] base,
                                               input logic [CW-1:0] off);
        logic [CW:0] sum;
        sum = (CW+1)'(base) + (CW+1)'(off);
        if (sum >= (CW+1)'(CAPACITY))
        begin
            sum = sum - (CW+1)'(CAPACITY);
        end
        return sum[IW-1:0];
    endfunction

    state_t            state_reg, state_next;
    logic [IW-1:0]     head_reg, head_next;
    logic [CW-1:0]     count_reg, count_next;
    logic              rev_reg, rev_next;
    logic [CW-1:0]     idx_reg, idx_next;

    logic                          valid_reg, valid_next;
    deq_pkg::status_t              status_reg, status_next;
    logic signed [deq_pkg::DATA_W-1:0] item_reg, item_next;
    logic                          last_reg, last_next;

    logic                          wr_en;
    logic [IW-1:0]                 wr_addr;
    logic [deq_pkg::DATA_W-1:0]    wr_data;
    logic                          rd_en;
    logic [IW-1:0]                 rd_addr;
    logic [deq_pkg::DATA_W-1:0]    rd_data;

    logic          is_full;
    logic          is_empty;
    logic          phys_front;
    logic [CW-1:0] list_off;

    assign is_full  = (count_reg == CW'(CAPACITY));
    assign is_empty = (count_reg == '0);

    deq_ram #(
        .DEPTH (CAPACITY),
        .AW    (IW),
        .DW    (deq_pkg::DATA_W)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        state_next  = state_reg;
        head_next   = head_reg;
        count_next  = count_reg;
        rev_next    = rev_reg;
        idx_next    = idx_reg;
        valid_next  = 1'b0;
        status_next = status_reg;
        item_next   = item_reg;
        last_next   = last_reg;
        wr_en       = 1'b0;
        wr_addr     = head_reg;
        wr_data     = value;
        rd_en       = 1'b0;
        rd_addr     = head_reg;
        phys_front  = 1'b0;
        list_off    = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    case (kind)
                        deq_pkg::KIND_PUSH_FRONT, deq_pkg::KIND_PUSH_BACK:
                        begin
                            valid_next = 1'b1;
                            item_next  = '0;
                            last_next  = 1'b1;
                            // front in logical order maps to the physical end
                            // chosen by the reversed flag
                            phys_front = (kind == deq_pkg::KIND_PUSH_FRONT) ^ rev_reg;
                            if (is_full)
                            begin
                                status_next = deq_pkg::STATUS_FULL;
                            end
                            else
                            begin
                                status_next = deq_pkg::STATUS_DONE;
                                wr_en       = 1'b1;
                                count_next  = count_reg + 1'b1;
                                if (phys_front)
                                begin
                                    head_next = (head_reg == '0) ? IW'(CAPACITY - 1)
                                                                 : head_reg - 1'b1;
                                    wr_addr   = head_next;
                                end
                                else
                                begin
                                    wr_addr = ring_add(head_reg, count_reg);
                                end
                            end
                        end
                        deq_pkg::KIND_POP_FRONT, deq_pkg::KIND_POP_BACK:
                        begin
                            phys_front = (kind == deq_pkg::KIND_POP_FRONT) ^ rev_reg;
                            if (is_empty)
                            begin
                                valid_next  = 1'b1;
                                status_next = deq_pkg::STATUS_UNDERFLOW;
                                item_next   = '0;
                                last_next   = 1'b1;
                            end
                            else
                            begin
                                // fetch the entry; the pop state then registers it as the result
                                rd_en      = 1'b1;
                                count_next = count_reg - 1'b1;
                                state_next = ST_POP;
                                if (phys_front)
                                begin
                                    rd_addr   = head_reg;
                                    head_next = ring_add(head_reg, CW'(1));
                                end
                                else
                                begin
                                    rd_addr = ring_add(head_reg, count_reg - 1'b1);
                                end
                            end
                        end
                        deq_pkg::KIND_REVERSE:
                        begin
                            rev_next    = ~rev_reg;
                            valid_next  = 1'b1;
                            status_next = deq_pkg::STATUS_DONE;
                            item_next   = '0;
                            last_next   = 1'b1;
                        end
                        deq_pkg::KIND_LIST:
                        begin
                            if (is_empty)
                            begin
                                valid_next  = 1'b1;
                                status_next = deq_pkg::STATUS_LIST_EMPTY;
                                item_next   = '0;
                                last_next   = 1'b1;
                            end
                            else
                            begin
                                // first fetch goes out now, index 0 in logical order
                                list_off   = rev_reg ? count_reg - 1'b1 : '0;
                                rd_en      = 1'b1;
                                rd_addr    = ring_add(head_reg, list_off);
                                idx_next   = CW'(1);
                                last_next  = (count_reg == CW'(1));
                                state_next = ST_LIST;
                            end
                        end
                        default:
                        begin
                            // unused command codes are dropped
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_POP:
            begin
                valid_next  = 1'b1;
                status_next = deq_pkg::STATUS_DONE;
                item_next   = rd_data;
                last_next   = 1'b1;
                state_next  = ST_IDLE;
            end
            ST_LIST:
            begin
                // emit the entry fetched last cycle, fetch the next one if any
                valid_next  = 1'b1;
                status_next = deq_pkg::STATUS_LISTED;
                item_next   = rd_data;
                last_next   = last_reg;
                if (idx_reg < count_reg)
                begin
                    list_off   = rev_reg ? count_reg - 1'b1 - idx_reg : idx_reg;
                    rd_en      = 1'b1;
                    rd_addr    = ring_add(head_reg, list_off);
                    idx_next   = idx_reg + 1'b1;
                    last_next  = (idx_reg == count_reg - 1'b1);
                end
                else
                begin
                    last_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // the pending-last flag for the list stream shares last_reg, so the
    // emitted last in the list state must come from the fetch bookkeeping
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            head_reg  <= '0;
            count_reg <= '0;
            rev_reg   <= 1'b0;
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            count_reg <= count_next;
            rev_reg   <= rev_next;
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    // result payload and the list fetch-ahead flag
    logic fetch_last_reg, fetch_last_next;

    always_comb
    begin
        fetch_last_next = fetch_last_reg;
        if (state_reg == ST_IDLE)
        begin
            fetch_last_next = (count_reg == CW'(1));
        end
        else if (state_reg == ST_LIST && idx_reg < count_reg)
        begin
            fetch_last_next = (idx_reg == count_reg - 1'b1);
        end
    end

    always_ff @(posedge clk)
    begin
        fetch_last_reg <= fetch_last_next;
        status_reg     <= status_next;
        item_reg       <= item_next;
        if (state_reg == ST_LIST)
        begin
            // the entry going out now was fetched with this flag
            last_reg <= fetch_last_reg;
        end
        else
        begin
            last_reg <= last_next;
        end
    end

    assign busy   = (state_reg != ST_IDLE);
    assign valid  = valid_reg;
    assign status = status_reg;
    assign item   = item_reg;
    assign last   = last_reg;

endmodule

`default_nettype wire

// ----- rtl/deq_checker.sv -----
// port-level checks for the double-ended queue top level, attached by bind
// depends on deq_pkg and double_ended_queue_with_reverse_top
`default_nettype none

module deq_checker (
    input wire logic                               clk,
    input wire logic                               rst_n,
    input wire logic                               start,
    input wire logic                               busy,
    input wire logic [deq_pkg::KIND_W-1:0]         kind,
    input wire logic                               valid,
    input wire logic [deq_pkg::STATUS_W-1:0]       status,
    input wire logic signed [deq_pkg::DATA_W-1:0]  item,
    input wire logic                               last
);

    // push and reverse commands answer in the next cycle
    a_quick_result: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (kind == deq_pkg::KIND_PUSH_FRONT ||
                            kind == deq_pkg::KIND_PUSH_BACK ||
                            kind == deq_pkg::KIND_REVERSE))
        |=> (valid && last))
        else $error("push or reverse did not answer in one cycle");

    // a list stream has no gaps
    a_list_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        (valid && !last) |=> (valid && status == deq_pkg::STATUS_LISTED))
        else $error("list stream broke before its last entry");

    // more results are pending only while the block reports busy
    a_busy_stream: assert property (@(posedge clk) disable iff (!rst_n)
        (valid && !last) |-> busy)
        else $error("stream pending while idle");

    // error and empty reports carry no item and end the transaction
    a_report_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (valid && (status == deq_pkg::STATUS_UNDERFLOW ||
                   status == deq_pkg::STATUS_FULL ||
                   status == deq_pkg::STATUS_LIST_EMPTY))
        |-> (item == '0 && last))
        else $error("error report with item or without last");

endmodule

bind double_ended_queue_with_reverse_top deq_checker u_deq_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .kind   (kind),
    .valid  (valid),
    .status (status),
    .item   (item),
    .last   (last)
);

`default_nettype wire

// ----- tb/sv/tb_double_ended_queue_with_reverse_top.sv -----
// self-checking testbench for double_ended_queue_with_reverse_top
// depends on deq_pkg and the block's rtl; holds its own deque predictor and checker
`default_nettype none

module tb_double_ended_queue_with_reverse_top;

    import deq_pkg::*;

    localparam int CAP          = CAPACITY_DEF;
    localparam int CMD_ITEMS    = 400;      // random transactions that do something
    localparam int CYCLE_LIMIT  = 200000;   // far above the slowest correct run
    localparam int DRAIN_CYCLES = 40;       // covers a full list stream plus latency
    localparam int MAX_REPORTS  = 10;

    // command codes the block does not decode
    localparam logic [KIND_W-1:0] KIND_SPARE_A = 3'd6;
    localparam logic [KIND_W-1:0] KIND_SPARE_B = 3'd7;

    // one expected result of the block
    typedef struct {
        status_t           st;
        logic [DATA_W-1:0] itm;
        logic              lst;
    } deq_result_t;

    // deque predictor plus in-order result checker
    class deque_scoreboard;
        logic [DATA_W-1:0] store [CAP];
        int                head;
        int                count;
        bit                rev;
        deq_result_t       expected_q [$];
        int                errors;

        function new();
            head   = 0;
            count  = 0;
            rev    = 1'b0;
            errors = 0;
        endfunction

        function void add_expected(status_t st, logic [DATA_W-1:0] itm, logic lst);
            deq_result_t r;
            r.st  = st;
            r.itm = itm;
            r.lst = lst;
            expected_q.push_back(r);
        endfunction

        // update the predicted deque for one accepted command transaction
        function void note_command(logic [KIND_W-1:0] k, logic [DATA_W-1:0] v);
            bit at_front;
            int pos;
            case (k)
                KIND_PUSH_FRONT, KIND_PUSH_BACK:
                    if (count >= CAP)
                        add_expected(STATUS_FULL, '0, 1'b1);
                    else
                    begin
                        at_front = (k == KIND_PUSH_FRONT) != rev;
                        if (at_front)
                        begin
                            head        = (head + CAP - 1) % CAP;
                            store[head] = v;
                        end
                        else
                            store[(head + count) % CAP] = v;
                        count++;
                        add_expected(STATUS_DONE, '0, 1'b1);
                    end
                KIND_POP_FRONT, KIND_POP_BACK:
                    if (count == 0)
                        add_expected(STATUS_UNDERFLOW, '0, 1'b1);
                    else
                    begin
                        at_front = (k == KIND_POP_FRONT) != rev;
                        if (at_front)
                        begin
                            add_expected(STATUS_DONE, store[head], 1'b1);
                            head = (head + 1) % CAP;
                        end
                        else
                            add_expected(STATUS_DONE, store[(head + count - 1) % CAP], 1'b1);
                        count--;
                    end
                KIND_REVERSE:
                begin
                    rev = ~rev;
                    add_expected(STATUS_DONE, '0, 1'b1);
                end
                KIND_LIST:
                    if (count == 0)
                        add_expected(STATUS_LIST_EMPTY, '0, 1'b1);
                    else
                        for (int i = 0; i < count; i++)
                        begin
                            pos = rev ? (count - 1 - i) : i;
                            add_expected(STATUS_LISTED, store[(head + pos) % CAP],
                                         (i + 1 == count));
                        end
                default: ;  // unused kinds: dropped by the block
            endcase
        endfunction

        // compare one result transaction with the oldest expectation
        function void check_result(logic [STATUS_W-1:0] st, logic [DATA_W-1:0] itm, logic lst);
            deq_result_t e;
            if (expected_q.size() == 0)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("unexpected result: status %0d item %h last %b", st, itm, lst);
                return;
            end
            e = expected_q.pop_front();
            if (st !== e.st || itm !== e.itm || lst !== e.lst)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display({"mismatch: expected status %0d item %h last %b,",
                              " got status %0d item %h last %b"},
                             e.st, e.itm, e.lst, st, itm, lst);
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    // clock, reset and block ports
    logic                     clk    = 1'b0;
    logic                     rst_n  = 1'b0;
    logic                     start  = 1'b0;
    logic [KIND_W-1:0]        kind   = '0;
    logic signed [DATA_W-1:0] value  = '0;
    logic                     busy;
    logic                     valid;
    logic [STATUS_W-1:0]      status;
    logic signed [DATA_W-1:0] item;
    logic                     last;

    int  cycle_count = 0;
    bit  no_idle     = 1'b0;   // stretch with back-to-back commands

    deque_scoreboard sb = new();

    double_ended_queue_with_reverse_top DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .kind   (kind),
        .value  (value),
        .valid  (valid),
        .status (status),
        .item   (item),
        .last   (last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // watchdog: a hung handshake or a lost result ends here
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // result monitor: every strobed cycle is a result transaction, sampled at the edge
    always @(posedge clk)
    begin
        if (rst_n && valid)
            sb.check_result(status, item, last);
    end

    // idle cycles before the next command, none inside a no-idle stretch
    function automatic int pick_gap();
        if (no_idle)
            return 0;
        return $urandom_range(0, 11);
    endfunction

    // payload biased toward the signed extremes
    function automatic logic [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'h0000_0000;
            3:       return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    // drive one command transaction; called at a rising edge, returns at the accepting edge
    // start stays high across back-to-back commands so it is never dropped and raised in one step
    task automatic send_cmd(input logic [KIND_W-1:0] k, input logic [DATA_W-1:0] v);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        kind  <= k;
        value <= v;
        // accepted at the edge where start is high and busy low
        do
            @(posedge clk);
        while (!(start && !busy));
        sb.note_command(k, v);
    endtask

    initial
    begin
        int done_items;
        int seg_left;
        int mode;
        int r;
        logic [KIND_W-1:0] k;

        // reset held low from the start, released at an edge
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty cases, one-entry reverse, extremes, reversed mapping, unused kinds
        send_cmd(KIND_POP_FRONT, pick_value());
        send_cmd(KIND_POP_BACK, pick_value());
        send_cmd(KIND_LIST, '0);
        send_cmd(KIND_REVERSE, '0);
        send_cmd(KIND_REVERSE, '0);
        send_cmd(KIND_PUSH_FRONT, 32'h8000_0000);
        send_cmd(KIND_LIST, '0);
        send_cmd(KIND_REVERSE, '0);
        send_cmd(KIND_PUSH_BACK, 32'h7fff_ffff);
        send_cmd(KIND_PUSH_FRONT, 32'hffff_ffff);
        send_cmd(KIND_PUSH_BACK, 32'h0000_0000);
        send_cmd(KIND_LIST, '0);
        send_cmd(KIND_REVERSE, '0);
        send_cmd(KIND_LIST, '0);
        send_cmd(KIND_PUSH_FRONT, 32'h1234_5678);
        send_cmd(KIND_POP_FRONT, '0);
        send_cmd(KIND_POP_BACK, '0);
        send_cmd(KIND_LIST, '0);
        send_cmd(KIND_REVERSE, '0);
        send_cmd(KIND_POP_FRONT, '0);
        send_cmd(KIND_POP_BACK, '0);
        send_cmd(KIND_POP_FRONT, '0);
        send_cmd(KIND_SPARE_A, pick_value());
        send_cmd(KIND_SPARE_B, pick_value());
        send_cmd(KIND_LIST, '0);

        // random: segments that fill, drain or mix, so full and underflow both get hit
        done_items = 0;
        seg_left   = 0;
        mode       = 0;
        while (done_items < CMD_ITEMS)
        begin
            if (seg_left == 0)
            begin
                mode     = $urandom_range(0, 2);
                seg_left = $urandom_range(10, 60);
                no_idle  = ($urandom_range(0, 3) == 0);
            end
            seg_left--;
            r = $urandom_range(0, 99);
            if (r < 3)
                k = $urandom_range(0, 1) ? KIND_SPARE_B : KIND_SPARE_A;   // ignored
            else
            begin
                case (mode)
                    0:  // fill
                        if (r < 73)
                            k = $urandom_range(0, 1) ? KIND_PUSH_FRONT : KIND_PUSH_BACK;
                        else if (r < 88)
                            k = $urandom_range(0, 1) ? KIND_POP_FRONT : KIND_POP_BACK;
                        else if (r < 95)
                            k = KIND_REVERSE;
                        else
                            k = KIND_LIST;
                    1:  // drain
                        if (r < 73)
                            k = $urandom_range(0, 1) ? KIND_POP_FRONT : KIND_POP_BACK;
                        else if (r < 88)
                            k = $urandom_range(0, 1) ? KIND_PUSH_FRONT : KIND_PUSH_BACK;
                        else if (r < 95)
                            k = KIND_REVERSE;
                        else
                            k = KIND_LIST;
                    default:  // mixed
                        if (r < 38)
                            k = $urandom_range(0, 1) ? KIND_PUSH_FRONT : KIND_PUSH_BACK;
                        else if (r < 73)
                            k = $urandom_range(0, 1) ? KIND_POP_FRONT : KIND_POP_BACK;
                        else if (r < 86)
                            k = KIND_REVERSE;
                        else
                            k = KIND_LIST;
                endcase
                done_items++;
            end
            send_cmd(k, pick_value());
        end

        // wait out every expected result, then the pipeline tail
        start <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.errors == 0 && sb.pending() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

`default_nettype wire

// ----- sim.f -----
rtl/deq_pkg.sv
rtl/deq_ram.sv
rtl/double_ended_queue_with_reverse_top.sv
rtl/deq_checker.sv
tb/sv/tb_double_ended_queue_with_reverse_top.sv
